[hw/rtl/lpe_pkg.sv]
`default_nettype none

package lpe_pkg;

	// Field widths
	localparam int ADV_W   = 8;
	localparam int LEVEL_W = 8;
	localparam int RGB_W   = 24;
	localparam int PHASE_W = 12;
	localparam int PROG_W  = 11;
	localparam int PROD_W  = LEVEL_W + PROG_W;
	localparam int CFG_IDX_W = 2;

	// Default for the animation frame interval
	localparam int FRAME_INTERVAL_MS_DEF = 30;

	// Pattern periods in ms
	localparam logic [PHASE_W-1:0] PERIOD_HEART = PHASE_W'(2000);
	localparam logic [PHASE_W-1:0] PERIOD_AMBER = PHASE_W'(2600);
	localparam logic [PHASE_W-1:0] PERIOD_RED   = PHASE_W'(1200);

	// Default peaks when the peak register is zero
	localparam logic [LEVEL_W-1:0] PEAK_DEF_HEART = LEVEL_W'(32);
	localparam logic [LEVEL_W-1:0] PEAK_DEF_AMBER = LEVEL_W'(48);
	localparam logic [LEVEL_W-1:0] PEAK_DEF_RED   = LEVEL_W'(96);

	localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFF_FFFF;

	// Reciprocal constants: q = (n * MAGIC) >> MAGIC_SHIFT is exact for n < 2^19
	localparam int MAGIC_SHIFT = 30;
	localparam int MAGIC_W     = 23;
	localparam int QFULL_W     = PROD_W + MAGIC_W;
	localparam longint MAGIC_150_L  = ((64'd1 << MAGIC_SHIFT) + 64'd149) / 64'd150;
	localparam longint MAGIC_200_L  = ((64'd1 << MAGIC_SHIFT) + 64'd199) / 64'd200;
	localparam longint MAGIC_1300_L = ((64'd1 << MAGIC_SHIFT) + 64'd1299) / 64'd1300;
	localparam logic [MAGIC_W-1:0] MAGIC_150  = MAGIC_W'(MAGIC_150_L);
	localparam logic [MAGIC_W-1:0] MAGIC_200  = MAGIC_W'(MAGIC_200_L);
	localparam logic [MAGIC_W-1:0] MAGIC_1300 = MAGIC_W'(MAGIC_1300_L);

	typedef enum logic [2:0] {
		MODE_OFF   = 3'd0,
		MODE_SOLID = 3'd1,
		MODE_HEART = 3'd2,
		MODE_AMBER = 3'd3,
		MODE_RED   = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_RGB  = 2'd1,
		REG_PEAK = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SPAN_150  = 2'd0,
		SPAN_200  = 2'd1,
		SPAN_1300 = 2'd2
	} span_t;

	// One ramp evaluation: base +/- (mag * progress) / span
	typedef struct packed {
		logic [LEVEL_W-1:0] base;
		logic [LEVEL_W-1:0] mag;
		logic               neg;
		logic [PROG_W-1:0]  progress;
		span_t              span;
	} ramp_req_t;

	// Side information that travels with the ramp
	typedef struct packed {
		logic             eval;
		logic [RGB_W-1:0] rgb;
	} item_tag_t;

endpackage

`default_nettype wire

[hw/rtl/lpe_if.sv]
`default_nettype none

interface lpe_tick_if;
	logic                          valid;
	logic                          ready;
	logic [lpe_pkg::ADV_W-1:0]     advance_ms;

	modport source (output valid, output advance_ms, input ready);
	modport sink (input valid, input advance_ms, output ready);
endinterface

interface lpe_result_if;
	logic                          valid;
	logic                          ready;
	logic [lpe_pkg::LEVEL_W-1:0]   level;
	logic [lpe_pkg::RGB_W-1:0]     pixel_rgb;

	modport source (output valid, output level, output pixel_rgb, input ready);
	modport sink (input valid, input level, input pixel_rgb, output ready);
endinterface

`default_nettype wire

[hw/rtl/lpe_ramp.sv]
`default_nettype none

// Two-stage ramp arithmetic: product, then division by the span constant
module lpe_ramp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        req_valid,
	input  wire lpe_pkg::ramp_req_t          req,
	input  wire lpe_pkg::item_tag_t          req_tag,
	output logic                             res_valid,
	output logic [lpe_pkg::LEVEL_W-1:0]      res_level,
	output lpe_pkg::item_tag_t               res_tag
);

	logic                              valid_s3;
	logic [lpe_pkg::PROD_W-1:0]        prod_s3;
	logic [lpe_pkg::LEVEL_W-1:0]       base_s3;
	logic                              neg_s3;
	lpe_pkg::span_t                    span_s3;
	lpe_pkg::item_tag_t                tag_s3;

	logic                              valid_s4;
	logic [lpe_pkg::LEVEL_W-1:0]       q_s4;
	logic [lpe_pkg::LEVEL_W-1:0]       base_s4;
	logic                              neg_s4;
	lpe_pkg::item_tag_t                tag_s4;

	logic [lpe_pkg::MAGIC_W-1:0]       magic;
	logic [lpe_pkg::QFULL_W-1:0]       qfull;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= req_valid;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 3: magnitude times progress
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= lpe_pkg::PROD_W'(req.mag) * lpe_pkg::PROD_W'(req.progress);
			base_s3 <= req.base;
			neg_s3  <= req.neg;
			span_s3 <= req.span;
			tag_s3  <= req_tag;
		end
	end

	// Pick the reciprocal of the span
	always_comb begin
		case (span_s3)
			lpe_pkg::SPAN_150:  magic = lpe_pkg::MAGIC_150;
			lpe_pkg::SPAN_200:  magic = lpe_pkg::MAGIC_200;
			lpe_pkg::SPAN_1300: magic = lpe_pkg::MAGIC_1300;
			default:            magic = lpe_pkg::MAGIC_150;
		endcase
	end

	assign qfull = lpe_pkg::QFULL_W'(prod_s3) * lpe_pkg::QFULL_W'(magic);

	// Stage 4: truncated quotient, never above the level range
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4    <= qfull[lpe_pkg::MAGIC_SHIFT +: lpe_pkg::LEVEL_W];
			base_s4 <= base_s3;
			neg_s4  <= neg_s3;
			tag_s4  <= tag_s3;
		end
	end

	// Result stays between the two ramp ends, so no clamp is needed
	assign res_level = neg_s4 ? (base_s4 - q_s4) : (base_s4 + q_s4);
	assign res_valid = valid_s4;
	assign res_tag   = tag_s4;

endmodule

`default_nettype wire

[hw/rtl/led_pattern_envelope_unit.sv]
// LED strip brightness envelope unit.
// Channels: "tick" carries one transaction per elapsed-time report (advance_ms);
// "result" carries a (level, pixel_rgb) transaction whenever the shown level or
// colour changes. A tick that changes nothing produces no result transaction.
// Configuration: write cfg_data to register cfg_index (0 mode, 1 rgb_value,
// 2 peak_brightness) with cfg_we high; any such write restarts the pattern.
// Write configuration only while no tick is in flight.
// Path: the tick passes five registers (input state update, segment select,
// product, reciprocal divide, output), the first loaded at the taking edge.
// Throughput: one tick per cycle; the pipeline and the output register all
// advance together, so the rate is set by how fast "result" is drained.
// Stall: while a result waits with ready low, the pipeline holds and tick.ready
// drops; ticks without a result never cause a stall.
// Reset (arst_n low): mode off, colour and peak zero, phase zero, a frame due,
// last output known as blank; no result is pending.
`default_nettype none

module led_pattern_envelope_unit #(
	parameter int FRAME_INTERVAL_MS = lpe_pkg::FRAME_INTERVAL_MS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lpe_tick_if.sink                           tick,
	lpe_result_if.source                       result,
	input  wire logic                          cfg_we,
	input  wire logic [lpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lpe_pkg::RGB_W-1:0]     cfg_data
);

	localparam int SinceW = $clog2(FRAME_INTERVAL_MS + 1);
	localparam int SumW   = ((SinceW > lpe_pkg::ADV_W) ? SinceW : lpe_pkg::ADV_W) + 1;
	localparam logic [SinceW-1:0] FrameSince = SinceW'(FRAME_INTERVAL_MS);
	localparam logic [SumW-1:0]   FrameSum   = SumW'(FRAME_INTERVAL_MS);

	// Configuration registers
	logic [2:0]                        mode_q;
	logic [lpe_pkg::RGB_W-1:0]         rgb_q;
	logic [lpe_pkg::LEVEL_W-1:0]       peak_q;

	// Pattern state
	logic [lpe_pkg::PHASE_W-1:0]       phase_q;
	logic [SinceW-1:0]                 since_q;
	logic [lpe_pkg::LEVEL_W-1:0]       shown_level_q;
	logic [lpe_pkg::RGB_W-1:0]         shown_rgb_q;
	logic                              shown_known_q;

	// Output register
	logic                              out_valid_q;
	logic [lpe_pkg::LEVEL_W-1:0]       out_level_q;
	logic [lpe_pkg::RGB_W-1:0]         out_rgb_q;

	// Stage 1
	logic                              valid_s1;
	logic                              eval_s1;
	logic [lpe_pkg::PHASE_W-1:0]       phase_s1;
	logic [2:0]                        mode_s1;

	// Stage 2
	logic                              valid_s2;
	lpe_pkg::ramp_req_t                req_s2;
	lpe_pkg::item_tag_t                tag_s2;

	logic                              adv;
	logic                              take;
	logic                              cfg_hit;
	logic                              animated;
	logic [lpe_pkg::PHASE_W-1:0]       period;
	logic [lpe_pkg::PHASE_W-1:0]       ph_sum;
	logic [lpe_pkg::PHASE_W-1:0]       ph_next;
	logic [SumW-1:0]                   since_sum;
	logic [SinceW-1:0]                 since_sat;
	logic                              due;
	logic                              eval_in;

	logic [lpe_pkg::LEVEL_W-1:0]       pk;
	logic [lpe_pkg::LEVEL_W-1:0]       from_v;
	logic [lpe_pkg::LEVEL_W-1:0]       to_v;
	logic [lpe_pkg::PHASE_W-1:0]       prog_v;
	lpe_pkg::span_t                    span_v;
	lpe_pkg::ramp_req_t                req_d;
	lpe_pkg::item_tag_t                tag_d;

	logic                              rv;
	logic [lpe_pkg::LEVEL_W-1:0]       rlevel;
	lpe_pkg::item_tag_t                rtag;
	logic [lpe_pkg::RGB_W-1:0]         show_rgb;
	logic                              emit;

	// Whole pipeline moves when the output register is free or being drained
	assign adv  = !out_valid_q || result.ready;
	assign take = tick.valid && adv;
	assign tick.ready = adv;

	assign cfg_hit = cfg_we && (cfg_index == lpe_pkg::REG_MODE ||
		cfg_index == lpe_pkg::REG_RGB || cfg_index == lpe_pkg::REG_PEAK);

	// Period of the current mode
	always_comb begin
		animated = 1'b1;
		case (mode_q)
			lpe_pkg::MODE_HEART: period = lpe_pkg::PERIOD_HEART;
			lpe_pkg::MODE_AMBER: period = lpe_pkg::PERIOD_AMBER;
			lpe_pkg::MODE_RED:   period = lpe_pkg::PERIOD_RED;
			default: begin
				period   = lpe_pkg::PERIOD_HEART;
				animated = 1'b0;
			end
		endcase
	end

	// Phase wraps with one subtract: phase stays below the period
	assign ph_sum  = phase_q + lpe_pkg::PHASE_W'(tick.advance_ms);
	assign ph_next = (ph_sum >= period) ? (ph_sum - period) : ph_sum;

	// Frame timer saturates at the interval
	assign since_sum = SumW'(since_q) + SumW'(tick.advance_ms);
	assign since_sat = (since_sum >= FrameSum) ? FrameSince : since_sum[SinceW-1:0];
	assign due       = (since_sat == FrameSince);

	// Off and solid evaluate on every tick; unused codes never do
	always_comb begin
		if (mode_q == lpe_pkg::MODE_OFF || mode_q == lpe_pkg::MODE_SOLID) begin
			eval_in = 1'b1;
		end else begin
			eval_in = animated && due;
		end
	end

	// Configuration and pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lpe_pkg::MODE_OFF;
			rgb_q   <= '0;
			peak_q  <= '0;
			phase_q <= '0;
			since_q <= FrameSince;
		end else if (cfg_hit) begin
			case (cfg_index)
				lpe_pkg::REG_MODE: mode_q <= cfg_data[2:0];
				lpe_pkg::REG_RGB:  rgb_q  <= cfg_data;
				lpe_pkg::REG_PEAK: peak_q <= cfg_data[lpe_pkg::LEVEL_W-1:0];
				default: ;
			endcase
			phase_q <= '0;
			since_q <= FrameSince;
		end else if (take) begin
			if (animated) begin
				phase_q <= ph_next;
			end
			since_q <= (animated && due) ? '0 : since_sat;
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eval_s1  <= eval_in;
			phase_s1 <= animated ? ph_next : phase_q;
			mode_s1  <= mode_q;
		end
	end

	// Segment select: ramp ends and progress for the phase
	always_comb begin
		pk     = peak_q;
		from_v = '0;
		to_v   = '0;
		prog_v = '0;
		span_v = lpe_pkg::SPAN_150;
		tag_d.eval = eval_s1;
		tag_d.rgb  = rgb_q;
		case (mode_s1)
			lpe_pkg::MODE_OFF: begin
				tag_d.rgb = '0;
			end
			lpe_pkg::MODE_SOLID: begin
				from_v = peak_q;
				to_v   = peak_q;
			end
			lpe_pkg::MODE_HEART: begin
				if (peak_q == '0) pk = lpe_pkg::PEAK_DEF_HEART;
				if (rgb_q == '0) tag_d.rgb = lpe_pkg::WHITE_RGB;
				if (phase_s1 < 12'd150) begin
					from_v = 8'd10; to_v = pk; prog_v = phase_s1;
				end else if (phase_s1 < 12'd300) begin
					from_v = pk; to_v = 8'd30; prog_v = phase_s1 - 12'd150;
				end else if (phase_s1 < 12'd450) begin
					from_v = 8'd30; to_v = pk; prog_v = phase_s1 - 12'd300;
				end else if (phase_s1 < 12'd650) begin
					from_v = pk; to_v = 8'd20; prog_v = phase_s1 - 12'd450;
					span_v = lpe_pkg::SPAN_200;
				end else begin
					from_v = 8'd10; to_v = 8'd10;
				end
			end
			lpe_pkg::MODE_AMBER: begin
				if (peak_q == '0) pk = lpe_pkg::PEAK_DEF_AMBER;
				span_v = lpe_pkg::SPAN_1300;
				if (phase_s1 < 12'd1300) begin
					from_v = 8'd8; to_v = pk; prog_v = phase_s1;
				end else begin
					from_v = pk; to_v = 8'd8; prog_v = phase_s1 - 12'd1300;
				end
			end
			lpe_pkg::MODE_RED: begin
				if (peak_q == '0) pk = lpe_pkg::PEAK_DEF_RED;
				if (phase_s1 < 12'd150) begin
					to_v = pk; prog_v = phase_s1;
				end else if (phase_s1 < 12'd300) begin
					from_v = pk; prog_v = phase_s1 - 12'd150;
				end else if (phase_s1 < 12'd600) begin
					from_v = '0;
				end else if (phase_s1 < 12'd750) begin
					to_v = pk; prog_v = phase_s1 - 12'd600;
				end else if (phase_s1 < 12'd900) begin
					from_v = pk; prog_v = phase_s1 - 12'd750;
				end else begin
					from_v = '0;
				end
			end
			default: begin
				tag_d.eval = 1'b0;
			end
		endcase
		req_d.base     = from_v;
		req_d.neg      = (from_v > to_v);
		req_d.mag      = req_d.neg ? (from_v - to_v) : (to_v - from_v);
		req_d.progress = prog_v[lpe_pkg::PROG_W-1:0];
		req_d.span     = span_v;
	end

	// Stage 2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2 <= req_d;
			tag_s2 <= tag_d;
		end
	end

	lpe_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (valid_s2),
		.req       (req_s2),
		.req_tag   (tag_s2),
		.res_valid (rv),
		.res_level (rlevel),
		.res_tag   (rtag)
	);

	// Change detection against the last shown output
	always_comb begin
		show_rgb = (rlevel == '0) ? '0 : rtag.rgb;
		if (rlevel == '0) begin
			emit = !(shown_known_q && shown_level_q == '0);
		end else begin
			emit = !(shown_known_q && shown_level_q == rlevel && shown_rgb_q == rtag.rgb);
		end
	end

	// Output register and shown state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			shown_level_q <= '0;
			shown_rgb_q   <= '0;
			shown_known_q <= 1'b1;
		end else if (cfg_hit) begin
			shown_known_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rv && rtag.eval && emit;
			if (rv && rtag.eval && emit) begin
				shown_level_q <= rlevel;
				shown_rgb_q   <= show_rgb;
				shown_known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_level_q <= rlevel;
			out_rgb_q   <= show_rgb;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.level     = out_level_q;
	assign result.pixel_rgb = out_rgb_q;

endmodule

`default_nettype wire
